// ===== hw/rtl/bounded_deque_with_search_core_assert.svh =====
// Assertion macros for the deque core
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define BDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bdq: assertion failed");
`define BDQ_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("bdq: forbidden condition seen");
`else
`define BDQ_ASSERT(lbl, prop)
`define BDQ_ASSERT_NEVER(lbl, prop)
`endif

`endif

// ===== hw/rtl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CntW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned ActW   = 3;
  localparam int unsigned StatW  = 2;

  localparam logic [ActW-1:0] ActPushBack  = 3'd0;
  localparam logic [ActW-1:0] ActPushFront = 3'd1;
  localparam logic [ActW-1:0] ActPopBack   = 3'd2;
  localparam logic [ActW-1:0] ActPopFront  = 3'd3;
  localparam logic [ActW-1:0] ActSearch    = 3'd4;

  localparam logic [StatW-1:0] StatDone  = 2'd0;
  localparam logic [StatW-1:0] StatEmpty = 2'd1;
  localparam logic [StatW-1:0] StatFull  = 2'd2;

  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  // offset stays below Depth, so one compare and subtract wraps the sum
  function automatic logic [AddrW-1:0] ring_add(logic [AddrW-1:0] base,
                                                logic [CntW-1:0]  off);
    logic [CntW:0] sum;
    sum = (CntW+1)'(base) + (CntW+1)'(off);
    if (sum >= (CntW+1)'(Depth)) begin
      sum = sum - (CntW+1)'(Depth);
    end
    return sum[AddrW-1:0];
  endfunction

endpackage

// ===== hw/rtl/bounded_deque_with_search_core.sv =====
// Push, full push, empty pop/search and unknown action: strobe in the cycle after start.
// Pop: one store read, then state StPop registers the strobe; busy while in StPop.
// Search: one store read per entry examined, up to every held entry; stops on a match.
// Push sustains one beat per cycle; pop and search hold busy, so a new start waits.
// Reset empties the queue; store contents are not cleared. Results cannot be stalled.
`include "bounded_deque_with_search_core_assert.svh"

module bounded_deque_with_search_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [bdq_pkg::ActW-1:0]   action_i,
  input  logic signed [bdq_pkg::DataW-1:0] value_i,
  output logic                       result_valid_o,
  output logic [bdq_pkg::StatW-1:0]  status_o,
  output logic signed [bdq_pkg::DataW-1:0] popped_value_o,
  output logic                       found_o,
  output logic [bdq_pkg::CntW-1:0]   entry_count_o
);
  import bdq_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPop  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] front_q, front_d;
  logic [CntW-1:0]  occ_q, occ_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [DataW-1:0] key_q, key_d;

  logic             strobe_q, strobe_d;
  logic [StatW-1:0] status_q, status_d;
  logic [DataW-1:0] popped_q, popped_d;
  logic             found_q, found_d;

  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             accept, full, empty, hit;
  logic             push_req;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign full   = (occ_q == CntFull);
  assign empty  = (occ_q == '0);
  assign hit    = (rd_data_q == key_q);

  assign push_req = accept && !full &&
                    (action_i == ActPushBack || action_i == ActPushFront);

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    occ_d    = occ_q;
    idx_d    = idx_q;
    key_d    = key_q;
    strobe_d = 1'b0;
    status_d = status_q;
    popped_d = popped_q;
    found_d  = found_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    rd_addr  = front_q;
    wr_addr  = front_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          status_d = StatDone;
          popped_d = '0;
          found_d  = 1'b0;
          strobe_d = 1'b1;
          unique case (action_i)
            ActPushBack: begin
              if (full) begin
                status_d = StatFull;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ring_add(front_q, occ_q);
                occ_d   = occ_q + 1'b1;
              end
            end
            ActPushFront: begin
              if (full) begin
                status_d = StatFull;
              end else begin
                wr_en   = 1'b1;
                front_d = ring_add(front_q, CntW'(Depth - 1));
                wr_addr = front_d;
                occ_d   = occ_q + 1'b1;
              end
            end
            ActPopBack: begin
              if (empty) begin
                status_d = StatEmpty;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = ring_add(front_q, occ_q - 1'b1);
                occ_d    = occ_q - 1'b1;
                strobe_d = 1'b0;
                state_d  = StPop;
              end
            end
            ActPopFront: begin
              if (empty) begin
                status_d = StatEmpty;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = front_q;
                front_d  = ring_add(front_q, CntW'(1));
                occ_d    = occ_q - 1'b1;
                strobe_d = 1'b0;
                state_d  = StPop;
              end
            end
            ActSearch: begin
              if (empty) begin
                status_d = StatEmpty;
              end else begin
                rd_en    = 1'b1;
                rd_addr  = front_q;
                idx_d    = '0;
                key_d    = value_i;
                strobe_d = 1'b0;
                state_d  = StScan;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StPop: begin
        popped_d = rd_data_q;
        strobe_d = 1'b1;
        state_d  = StIdle;
      end
      StScan: begin
        if (hit || (idx_q == occ_q - 1'b1)) begin
          found_d  = hit;
          strobe_d = 1'b1;
          state_d  = StIdle;
        end else begin
          idx_d   = idx_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = ring_add(front_q, idx_d);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      front_q  <= '0;
      occ_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      occ_q    <= occ_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    key_q    <= key_d;
    status_q <= status_d;
    popped_q <= popped_d;
    found_q  <= found_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign result_valid_o = strobe_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign found_o        = found_q;
  assign entry_count_o  = occ_q;

  `BDQ_ASSERT(a_occ_bounded, occ_q <= CntFull)
  `BDQ_ASSERT(a_pop_strobe, (state_q == StPop) |=> strobe_q)
  `BDQ_ASSERT(a_push_grows, push_req |=> (occ_q == $past(occ_q) + 1'b1))
  `BDQ_ASSERT_NEVER(a_found_done, strobe_q && found_q && (status_q != StatDone))

endmodule
